// ----- rtl/core/cgs_pkg.sv -----
package cgs_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] CSR_CURVE_EXP   = 2'd1;
   localparam logic [1:0] CSR_NUM_CHAN    = 2'd2;

   localparam logic [15:0] RATE_RESET     = 16'd12288;
   localparam logic [15:0] CURVE_RESET    = 16'd256;
   localparam logic [6:0]  NUM_CHAN_RESET = 7'd1;

   localparam logic signed [15:0] LINEAR_POS = 16'sd256;
   localparam logic signed [15:0] LINEAR_NEG = -16'sd256;

   localparam logic [16:0] Q16_ONE = 17'd65536;
   localparam logic [24:0] SPAN_ONE = 25'd1;

   typedef struct packed {
      logic [5:0]         channel;
      logic signed [31:0] sample_in;
      logic [19:0]        glide_ms;
      logic               reset_request;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample_out;
      logic [5:0]         out_channel;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        sample_rate_khz;
      logic signed [15:0] curve_exponent;
      logic [6:0]         num_channels;
   } cfg_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic [5:0]         channel;
      logic signed [31:0] sample_in;
      logic [24:0]        span;
      logic               reset_request;
   } job_type;

   // Per-channel state word.
   typedef struct packed {
      logic signed [31:0] last_target;
      logic signed [31:0] last_output;
      logic signed [31:0] glide_start;
      logic signed [32:0] glide_delta;
      logic [24:0]        samples_left;
   } entry_type;

   typedef logic [29:0] fac_table_type [16];

   function automatic logic [63:0] isqrt_const(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Factors 2^(-2^-(k+1)) in Q30 for entry k, each the square root of the one before.
   function automatic fac_table_type gen_fac_table();
      fac_table_type t;
      logic [63:0]   f;
      f = isqrt_const(64'd1 << 59);
      for (int k = 0; k < 16; k++) begin
         t[k] = f[29:0];
         f = isqrt_const(f << 30);
      end
      return t;
   endfunction

   localparam fac_table_type FAC_TABLE = gen_fac_table();

endpackage

// ----- rtl/core/curved_glide_slew.sv -----
// Per-channel glide for interleaved multichannel audio in Q16.16.
// A request on the req_ channel carries a channel, a target sample, a glide
// time in ms and a reset request; it is taken when req_valid is high and
// req_stall is low. Each request yields exactly one response on the rsp_
// channel (glided sample and its channel), in request order.
// The front registers the request and turns the glide time into a span in
// samples with one multiply; a two-entry queue then hands it to the back.
// The back works on one request at a time: a state read, then a 17-step
// divider for progress, 16 squaring steps for the logarithm, one scaling
// multiply, 16 exponent steps, and the final multiply and saturation.
// A linear glide skips the logarithm and exponent steps, and a snap to
// the target goes from the state read straight to the write. The iterative
// back end sets the sustained rate.
// After reset the back clears the per-channel state memory, one entry per
// cycle over all MAX_CHANNELS entries, and holds req_stall high meanwhile.
// Configuration writes on the csr_ channel are always taken (csr_ready is
// tied high) and are meant to happen while the block is idle.
// When rsp_stall is high the response is held; the back can finish one
// more request and wait with it in its write state, and the front keeps
// taking requests until the queue and its own register are full.
module curved_glide_slew #(
   parameter int MAX_CHANNELS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cgs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cgs_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);

   import cgs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    clearing;
   logic    queue_full;
   logic    queue_not_empty;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type head;

   // The register file never pushes back.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_RATE: cfg_in.sample_rate_khz = csr_data;
            CSR_CURVE_EXP:   cfg_in.curve_exponent  = $signed(csr_data);
            CSR_NUM_CHAN:    cfg_in.num_channels    = csr_data[6:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate_khz <= RATE_RESET;
         cfg_ff.curve_exponent  <= $signed(CURVE_RESET);
         cfg_ff.num_channels    <= NUM_CHAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: takes requests and works out the glide span.
   cgs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .sample_rate_khz (cfg_ff.sample_rate_khz),
      .hold            (clearing),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   cgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head      (head),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // Back: per-channel state, curve evaluation and the response register.
   cgs_back #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .not_empty   (queue_not_empty),
      .pop         (pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/core/cgs_ram.sv -----
module cgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/core/cgs_front.sv -----
module cgs_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  cgs_pkg::req_type req_payload,
   input  logic [15:0]     sample_rate_khz,
   input  logic            hold,
   input  logic            queue_full,
   output logic            push,
   output cgs_pkg::job_type push_job
);

   import cgs_pkg::*;

   logic        front_valid_ff;
   logic        front_valid_in;
   req_type     front_req_ff;
   logic        accept;
   logic [35:0] span_prod;
   logic [35:0] span_round;

   assign req_stall = hold || (front_valid_ff && queue_full);
   assign accept    = req_valid && !req_stall;
   assign push      = front_valid_ff && !queue_full;

   // Span in samples: round(ms * rate) + 1, both in fixed point.
   assign span_prod  = 36'(front_req_ff.glide_ms) * 36'(sample_rate_khz);
   assign span_round = span_prod + 36'd2048;

   always_comb begin
      push_job.channel       = front_req_ff.channel;
      push_job.sample_in     = front_req_ff.sample_in;
      push_job.span          = 25'(span_round >> 12) + SPAN_ONE;
      push_job.reset_request = front_req_ff.reset_request;
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         front_req_ff <= req_payload;
      end
   end

endmodule

// ----- rtl/core/cgs_queue.sv -----
module cgs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cgs_pkg::job_type push_job,
   input  logic             pop,
   output cgs_pkg::job_type head,
   output logic             not_empty,
   output logic             full
);

   import cgs_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/cgs_back.sv -----
module cgs_back #(
   parameter int MAX_CHANNELS = 64,
   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cgs_pkg::cfg_type cfg,
   input  cgs_pkg::job_type head,
   input  logic             not_empty,
   output logic             pop,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cgs_pkg::rsp_type rsp_payload
);

   import cgs_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECIDE, ST_DIV, ST_CURVE, ST_LOG, ST_SCALE,
      ST_EXP_SETUP, ST_EXP, ST_ROUND, ST_APPLY, ST_MUL, ST_SUM, ST_WRITE
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               pending_ff, pending_in;
   job_type            item_ff, item_in;
   logic [AW-1:0]      idx_ff, idx_in;
   entry_type          entry_ff, entry_in;
   logic signed [31:0] result_ff, result_in;
   logic [24:0]        rem_ff, rem_in;
   logic [16:0]        quo_ff, quo_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               dir_ff, dir_in;
   logic [15:0]        a_ff, a_in;
   logic [3:0]         pos_ff, pos_in;
   logic [30:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [28:0]        q_ff, q_in;
   logic [4:0]         ip_ff, ip_in;
   logic [30:0]        r_ff, r_in;
   logic [16:0]        pw_ff, pw_in;
   logic [16:0]        f_ff, f_in;
   logic signed [50:0] prod_ff, prod_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [AW-1:0]   idx_table [64];
   entry_type       rd_entry;
   logic [$bits(entry_type)-1:0] rd_data;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_entry;

   // Decide-stage values.
   logic            pend;
   logic            last_ch;
   entry_type       new_entry;
   logic [24:0]     num;

   // Iteration values.
   logic [25:0]     div_shift;
   logic [25:0]     div_diff;
   logic            div_ge;
   logic            linear;
   logic [15:0]     a_abs;
   logic            delta_pos;
   logic            dir_c;
   logic [16:0]     x_c;
   logic [3:0]      lead;
   logic [61:0]     sq;
   logic [31:0]     sq_top;
   logic [20:0]     mag_log;
   logic [36:0]     scaled;
   logic [12:0]     ip_full;
   logic [61:0]     exp_prod;
   logic [4:0]      sh;
   logic [31:0]     round_sum;
   logic [50:0]     prod_mag;
   logic [34:0]     inc_mag;
   logic signed [35:0] inc;
   logic signed [35:0] sum_v;
   logic            out_free;

   for (genvar g = 0; g < 64; g++) begin : g_idx
      assign idx_table[g] = AW'(g % MAX_CHANNELS);
   end

   cgs_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (pop),
      .rd_addr (idx_table[head.channel]),
      .rd_data (rd_data)
   );

   assign rd_entry    = entry_type'(rd_data);
   assign pop         = (state_ff == ST_IDLE) && not_empty;
   assign clearing    = (state_ff == ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wr_entry             = entry_ff;
      wr_entry.last_output = result_ff;
      wr_addr              = idx_ff;
      wr_en                = 1'b0;
      if (state_ff == ST_CLEAR) begin
         wr_entry = '0;
         wr_addr  = clr_ff;
         wr_en    = 1'b1;
      end else if (state_ff == ST_WRITE && out_free) begin
         wr_en = 1'b1;
      end
   end

   // Decide.
   always_comb begin
      pend      = pending_ff || item_ff.reset_request;
      last_ch   = (cfg.num_channels != 7'd0)
                  && ({1'b0, item_ff.channel} == (cfg.num_channels - 7'd1));
      new_entry = rd_entry;
      if (item_ff.span == SPAN_ONE || pend) begin
         new_entry.last_target = item_ff.sample_in;
         if (item_ff.span != SPAN_ONE) begin
            new_entry.samples_left = 25'd0;
         end
      end else if (item_ff.sample_in != rd_entry.last_target) begin
         new_entry.glide_start  = rd_entry.last_output;
         new_entry.glide_delta  = $signed({item_ff.sample_in[31], item_ff.sample_in})
                                  - $signed({rd_entry.last_output[31],
                                             rd_entry.last_output});
         new_entry.samples_left = item_ff.span - SPAN_ONE;
         new_entry.last_target  = item_ff.sample_in;
      end else if (rd_entry.samples_left != 25'd0) begin
         new_entry.samples_left = rd_entry.samples_left - 25'd1;
      end else begin
         new_entry.last_target = item_ff.sample_in;
      end
      num = (new_entry.samples_left > item_ff.span) ? 25'd0
            : item_ff.span - new_entry.samples_left;
   end

   // Datapath pieces.
   always_comb begin
      div_shift = (cnt_ff == 5'd0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      div_ge    = div_shift >= {1'b0, item_ff.span};
      div_diff  = div_shift - {1'b0, item_ff.span};

      linear    = (cfg.curve_exponent == LINEAR_POS) || (cfg.curve_exponent == LINEAR_NEG);
      a_abs     = cfg.curve_exponent[15] ? 16'(-cfg.curve_exponent)
                  : 16'(cfg.curve_exponent);
      delta_pos = !entry_ff.glide_delta[32] && (entry_ff.glide_delta != 33'sd0);
      dir_c     = (!cfg.curve_exponent[15]) == delta_pos;
      x_c       = dir_c ? quo_ff : Q16_ONE - quo_ff;
      lead      = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (x_c[i]) begin
            lead = 4'(i);
         end
      end

      sq      = 62'(m_ff) * 62'(m_ff);
      sq_top  = sq[61:30];
      mag_log = {5'd16 - {1'b0, pos_ff}, 16'd0} - 21'(frac_ff);
      scaled  = 37'(mag_log) * 37'(a_ff) + 37'd128;
      ip_full = q_ff[28:16];
      exp_prod = 62'(r_ff) * 62'(FAC_TABLE[cnt_ff[3:0]]);
      sh        = 5'd14 + ip_ff;
      round_sum = 32'(r_ff) + (32'd1 << (sh - 5'd1));

      prod_mag = prod_ff[50] ? 51'(-prod_ff) : 51'(prod_ff);
      inc_mag  = 35'((prod_mag + 51'd32768) >> 16);
      inc      = prod_ff[50] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
      sum_v    = 36'(entry_ff.glide_start) + inc;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pending_in   = pending_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      entry_in     = entry_ff;
      result_in    = result_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      dir_in       = dir_ff;
      a_in         = a_ff;
      pos_in       = pos_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      q_in         = q_ff;
      ip_in        = ip_ff;
      r_in         = r_ff;
      pw_in        = pw_ff;
      f_in         = f_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_CHANNELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (not_empty) begin
               item_in  = head;
               idx_in   = idx_table[head.channel];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            entry_in   = new_entry;
            pending_in = pend;
            rem_in     = num;
            quo_in     = 17'd0;
            cnt_in     = 5'd0;
            if (item_ff.span == SPAN_ONE) begin
               result_in = item_ff.sample_in;
               state_in  = ST_WRITE;
            end else if (pend) begin
               result_in  = item_ff.sample_in;
               pending_in = !last_ch;
               state_in   = ST_WRITE;
            end else if (item_ff.sample_in != rd_entry.last_target
                         || rd_entry.samples_left != 25'd0) begin
               state_in = ST_DIV;
            end else begin
               result_in = item_ff.sample_in;
               state_in  = ST_WRITE;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[24:0] : div_shift[24:0];
            quo_in = {quo_ff[15:0], div_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               cnt_in   = 5'd0;
               state_in = ST_CURVE;
            end
         end
         ST_CURVE: begin
            dir_in = dir_c;
            a_in   = a_abs;
            pos_in = lead;
            m_in   = 31'(x_c[15:0]) << (5'd30 - {1'b0, lead});
            frac_in = 16'd0;
            cnt_in  = 5'd0;
            if (linear) begin
               f_in     = quo_ff;
               state_in = ST_MUL;
            end else if (x_c[16] || a_abs == 16'd0) begin
               pw_in    = Q16_ONE;
               state_in = ST_APPLY;
            end else if (x_c == 17'd0) begin
               pw_in    = 17'd0;
               state_in = ST_APPLY;
            end else begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            if (sq_top[31]) begin
               m_in = sq_top[31:1];
               frac_in[4'(5'd15 - cnt_ff)] = 1'b1;
            end else begin
               m_in = sq_top[30:0];
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               cnt_in   = 5'd0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            q_in     = 29'(scaled >> 8);
            state_in = ST_EXP_SETUP;
         end
         ST_EXP_SETUP: begin
            cnt_in = 5'd0;
            r_in   = 31'd1 << 30;
            ip_in  = 5'(ip_full);
            if (ip_full > 13'd16) begin
               pw_in    = 17'd0;
               state_in = ST_APPLY;
            end else begin
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (q_ff[4'(5'd15 - cnt_ff)]) begin
               r_in = 31'(exp_prod >> 30);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               cnt_in   = 5'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            pw_in    = 17'(round_sum >> sh);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            f_in     = dir_ff ? pw_ff : Q16_ONE - pw_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = 51'(entry_ff.glide_delta) * 51'($signed({1'b0, f_ff}));
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_v > 36'sd2147483647) begin
               result_in = 32'sh7FFFFFFF;
            end else if (sum_v < -36'sd2147483648) begin
               result_in = 32'sh80000000;
            end else begin
               result_in = 32'(sum_v);
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.sample_out  = result_ff;
               rsp_in.out_channel = item_ff.channel;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      idx_ff    <= idx_in;
      entry_ff  <= entry_in;
      result_ff <= result_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      dir_ff    <= dir_in;
      a_ff      <= a_in;
      pos_ff    <= pos_in;
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      q_ff      <= q_in;
      ip_ff     <= ip_in;
      r_ff      <= r_in;
      pw_ff     <= pw_in;
      f_ff      <= f_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

endmodule
